@@ rtl/pwlcs_pkg.sv @@
// Shared widths, register indexes and the control/status bundles of the curve sampler.
// Used by every other module of the block; depends on nothing.
`timescale 1ns / 1ps

package pwlcs_pkg;

    // Field and register widths.
    localparam int PC_W       = 5;
    localparam int X_W        = 17;
    localparam int Y_W        = 32;
    localparam int SC_W       = 17;
    localparam int SI_W       = 16;
    localparam int PI_W       = 4;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Sample x as a full quotient; it may exceed one for indexes past the count.
    localparam int XQ_W   = 32;
    // Shared divider: quotient, remainder and dividend widths.
    localparam int QUO_W  = 34;
    localparam int REM_W  = 17;
    localparam int DVD_W  = QUO_W + REM_W;
    // Magnitude of the y step times the x offset.
    localparam int PROD_W = Y_W + X_W;
    // Start y plus the signed rounded quotient, before saturation.
    localparam int SUM_W  = QUO_W + 2;

    localparam int              CNT_W     = 6;
    localparam logic [CNT_W-1:0] DIV_STEPS = 6'd34;

    localparam logic [X_W-1:0] X_ONE = 17'h10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

    // Request kinds.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic xdiv_start;
        logic x_zero;
        logic take_x;
        logic scan_init;
        logic scan_step;
        logic mul_go;
        logic mul;
        logic idiv_start;
        logic finish_hit;
        logic finish_flat;
        logic finish_miss;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic d_zero;
        logic n_zero;
        logic div_done;
        logic seg_hit;
        logic zero_width;
        logic scan_end;
    } sts_t;

endpackage

@@ rtl/pwlcs_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by both divisions of a sample.
// Depends on pwlcs_pkg for its widths and step count.
`timescale 1ns / 1ps

module pwlcs_divider
    import pwlcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [DVD_W-1:0] dividend,
    input  logic [REM_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output logic             done
);

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [REM_W:0] trial;
    logic           ge;

    // One restoring step: shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? REM_W'(trial - {1'b0, dvs_reg}) : trial[REM_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], ge};
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= DIV_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Remainder and quotient shift register; the upper dividend bits seed the remainder.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= dividend[DVD_W-1:QUO_W];
            quo_reg <= dividend[QUO_W-1:0];
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

@@ rtl/pwlcs_datapath.sv @@
// Datapath of the curve sampler: configuration registers, breakpoint memory, segment
// compare, multiplier, shared divider and result registers. Depends on pwlcs_pkg.
`timescale 1ns / 1ps

module pwlcs_datapath
    import pwlcs_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PI_W-1:0]       point_index,
    input  logic [X_W-1:0]        point_x,
    input  logic signed [Y_W-1:0] point_y,
    input  logic [SI_W-1:0]       sample_index,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic signed [Y_W-1:0] sample_value,
    output logic                  found,
    output logic                  done
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PTR_W = $clog2(MAX_POINTS + 1);

    // Configuration registers.
    logic [PC_W-1:0]       point_count_reg;
    logic signed [Y_W-1:0] end_y_reg;
    logic [SC_W-1:0]       sample_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= PC_W'(1);
            end_y_reg        <= '0;
            sample_count_reg <= SC_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POINT_COUNT:  point_count_reg  <= cfg_data[PC_W-1:0];
                CFG_END_Y:        end_y_reg        <= cfg_data[Y_W-1:0];
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[SC_W-1:0];
                default:          ;
            endcase
        end
    end

    // Points in use, clipped to the table depth, and the sample spacing divisor.
    logic [PTR_W-1:0] n_pts;
    logic [SC_W-1:0]  d_val;

    always_comb
    begin
        if (32'(point_count_reg) > 32'(MAX_POINTS))
            n_pts = PTR_W'(MAX_POINTS);
        else
            n_pts = PTR_W'(point_count_reg);
        d_val = (sample_count_reg > SC_W'(1)) ? sample_count_reg - 1'b1 : '0;
    end

    // Breakpoint memory: one write port for loads, one registered read port for the scan.
    logic [X_W-1:0]        mem_x [MAX_POINTS];
    logic signed [Y_W-1:0] mem_y [MAX_POINTS];
    logic [X_W-1:0]        rd_x_reg;
    logic signed [Y_W-1:0] rd_y_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic                  slot_ok;

    assign slot_ok = (32'(point_index) < 32'(MAX_POINTS));
    assign wr_addr = IDX_W'(point_index);
    assign rd_addr = cmd.scan_init ? '0 : IDX_W'(ptr_reg + PTR_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            mem_x[wr_addr] <= point_x;
            mem_y[wr_addr] <= point_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // Sample x and the scan pointer.
    logic [XQ_W-1:0]       x_reg;
    logic [X_W-1:0]        prev_x_reg;
    logic signed [Y_W-1:0] prev_y_reg;
    logic [QUO_W-1:0]      quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.x_zero)
            x_reg <= '0;
        else if (cmd.take_x)
            x_reg <= quotient[XQ_W-1:0];
        if (cmd.scan_step)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
    end

    // Segment end: the next breakpoint, or x of one and the end y past the last one.
    logic                  at_end;
    logic [X_W-1:0]        end_x;
    logic signed [Y_W-1:0] end_y_sel;

    always_comb
    begin
        at_end    = (ptr_reg == n_pts);
        end_x     = at_end ? X_ONE : rd_x_reg;
        end_y_sel = at_end ? end_y_reg : rd_y_reg;
    end

    assign sts.d_zero     = (d_val == '0);
    assign sts.n_zero     = (n_pts == '0);
    assign sts.seg_hit    = (ptr_reg != '0) && (x_reg >= XQ_W'(prev_x_reg))
                            && (x_reg <= XQ_W'(end_x));
    assign sts.zero_width = (end_x == prev_x_reg);
    assign sts.scan_end   = at_end;

    // Interpolation operands: sign and magnitude of the y step, x offset and span.
    logic signed [Y_W:0]   dy;
    logic signed [Y_W:0]   dy_abs;
    logic                  neg_reg;
    logic [Y_W-1:0]        mag_reg;
    logic [X_W-1:0]        dx_reg, w_reg;
    logic signed [Y_W-1:0] sy_reg;
    logic [PROD_W-1:0]     prod, prod_reg;

    always_comb
    begin
        dy     = {end_y_sel[Y_W-1], end_y_sel} - {prev_y_reg[Y_W-1], prev_y_reg};
        dy_abs = dy[Y_W] ? -dy : dy;
    end

    assign prod = {{X_W{1'b0}}, mag_reg} * {{Y_W{1'b0}}, dx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            neg_reg <= dy[Y_W];
            mag_reg <= dy_abs[Y_W-1:0];
            dx_reg  <= X_W'(x_reg - XQ_W'(prev_x_reg));
            w_reg   <= end_x - prev_x_reg;
            sy_reg  <= prev_y_reg;
        end
        if (cmd.mul)
            prod_reg <= prod;
    end

    // Shared divider: the sample x first, then the rounded interpolation step.
    logic [DVD_W-1:0] dvd;
    logic [REM_W-1:0] dvs;

    always_comb
    begin
        if (cmd.xdiv_start)
        begin
            dvd = DVD_W'({sample_index, FRAC_W'(0)}) + DVD_W'(d_val >> 1);
            dvs = REM_W'(d_val);
        end
        else
        begin
            dvd = DVD_W'(prod_reg) + DVD_W'(w_reg >> 1);
            dvs = REM_W'(w_reg);
        end
    end

    pwlcs_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.xdiv_start || cmd.idiv_start),
        .dividend (dvd),
        .divisor  (dvs),
        .quotient (quotient),
        .done     (sts.div_done)
    );

    // Apply the sign, add the start y and saturate to 32 bits.
    logic signed [SUM_W-1:0] q_ext, term, sum;
    logic signed [Y_W-1:0]   sat_val;

    always_comb
    begin
        q_ext = {2'b00, quotient};
        term  = neg_reg ? -q_ext : q_ext;
        sum   = {{(SUM_W-Y_W){sy_reg[Y_W-1]}}, sy_reg} + term;
        if (sum[SUM_W-1:Y_W-1] == '0 || sum[SUM_W-1:Y_W-1] == '1)
            sat_val = sum[Y_W-1:0];
        else if (sum[SUM_W-1])
            sat_val = {1'b1, {(Y_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(Y_W-1){1'b1}}};
    end

    // Result registers and the one-cycle strobe.
    logic signed [Y_W-1:0] value_reg;
    logic                  found_reg;
    logic                  done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish_hit)
        begin
            value_reg <= sat_val;
            found_reg <= 1'b1;
        end
        else if (cmd.finish_flat)
        begin
            value_reg <= prev_y_reg;
            found_reg <= 1'b1;
        end
        else if (cmd.finish_miss)
        begin
            value_reg <= '0;
            found_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish_hit || cmd.finish_flat || cmd.finish_miss;
    end

    assign sample_value = value_reg;
    assign found        = found_reg;
    assign done         = done_reg;

endmodule

@@ rtl/pwlcs_ctrl.sv @@
// Controller of the curve sampler: sequences the x division, the segment scan and the
// interpolation. Depends on pwlcs_pkg for the command and status bundles.
`timescale 1ns / 1ps

module pwlcs_ctrl
    import pwlcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic kind,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_XDIV = 6'b000010,
        S_SCAN = 6'b000100,
        S_MUL  = 6'b001000,
        S_DLD  = 6'b010000,
        S_IDIV = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (sts.d_zero)
                    begin
                        cmd.x_zero    = 1'b1;
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        cmd.xdiv_start = 1'b1;
                        state_next     = S_XDIV;
                    end
                end
            end
            S_XDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.take_x    = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.n_zero)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (sts.seg_hit)
                begin
                    if (sts.zero_width)
                    begin
                        cmd.finish_flat = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.mul_go = 1'b1;
                        state_next = S_MUL;
                    end
                end
                else if (sts.scan_end)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DLD;
            end
            S_DLD:
            begin
                cmd.idiv_start = 1'b1;
                state_next     = S_IDIV;
            end
            S_IDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    // Every finishing command returns the controller to idle.
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_hit || cmd.finish_flat || cmd.finish_miss) |=> (state_reg == S_IDLE))
        else $error("controller not idle after finishing a request");

    // At most one kind of result is produced at a time.
    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.finish_hit, cmd.finish_flat, cmd.finish_miss}))
        else $error("more than one result command at once");

    // A sample request always occupies the block.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_SAMPLE) |=> busy)
        else $error("sample request accepted without going busy");

    // A load request completes in its accept cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_LOAD) |=> !busy)
        else $error("load request left the block busy");
`endif

endmodule

@@ rtl/piecewise_linear_curve_sampler.sv @@
// Top level of the piecewise linear curve sampler: joins controller and datapath.
// Depends on pwlcs_pkg, pwlcs_ctrl, pwlcs_datapath and pwlcs_divider.
`timescale 1ns / 1ps

// Usage
// A request is taken on a rising edge with start high and busy low. A load request
// (kind 0) writes one breakpoint slot in that cycle and busy stays low, so another
// request may follow at once. A sample request (kind 1) raises busy until its result.
// The result appears on sample_value and found for exactly one cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle. Busy is low
// again in the done cycle, so the next request may be taken at the edge ending it.
// The shared 34-step divider is used once for the sample x and once for the rounded
// interpolation step, and the scan goes one breakpoint a cycle through the single
// memory read port. When sample_count is 0 or 1, x is zero and the x division is
// skipped. Configuration writes take effect at once and must be made only while the
// block is idle; the block itself leaves this unchecked. Reset returns the controller
// to idle and the registers to a point count of 1, end y of 0 and a sample count of 2.
module piecewise_linear_curve_sampler
    import pwlcs_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [PI_W-1:0]       point_index,
    input  logic [X_W-1:0]        point_x,
    input  logic signed [Y_W-1:0] point_y,
    input  logic [SI_W-1:0]       sample_index,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic signed [Y_W-1:0] sample_value,
    output logic                  found,
    output logic                  done
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing.
    pwlcs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Storage and arithmetic.
    pwlcs_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_index  (point_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .sample_index (sample_index),
        .cmd          (cmd),
        .sts          (sts),
        .sample_value (sample_value),
        .found        (found),
        .done         (done)
    );

endmodule
